FILE: hw/rtl/bilinear_image_scaler_assert.svh
// Assertion macros for the RTL of the bilinear scaler.
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH

// Checks a property on every rising clock edge while reset is released.
`define BIS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define BIS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`BIS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: hw/rtl/bis_pkg.sv
package bis_pkg;

	localparam int DIM_W = 12;
	localparam int SDIM_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_W = 2'd0,
		CFG_SRC_H = 2'd1,
		CFG_DST_W = 2'd2,
		CFG_DST_H = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic             req_type;
		logic [13:0]      src_addr;
		logic [7:0]       in_blue;
		logic [7:0]       in_green;
		logic [7:0]       in_red;
		logic [7:0]       in_alpha;
		logic [DIM_W-1:0] dst_col;
		logic [DIM_W-1:0] dst_row;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_alpha;
		logic [1:0] status;
	} out_item_t;

endpackage

FILE: hw/rtl/bilinear_image_scaler.sv
// Bilinear image scaler.
// Input beats are taken at a rising edge with start high and busy low. A beat with
// req_type 0 stores one BGRA source pixel at raster address src_addr; a beat with
// req_type 1 computes the destination pixel (dst_col, dst_row) and yields one result.
// Each result is shown on result for exactly one cycle with result_valid high; the
// receiver cannot stall, so nothing downstream ever holds the pipeline.
// The four size registers are written through cfg_valid/cfg_ready (always ready).
// Every register write restarts a one-bit-per-cycle divider that forms the x and y
// step ratios; busy stays high while it runs. A compute beat first passes the
// coordinate divider (two quotient bits per cycle) and then steps through its four
// neighbors on the single source memory port, one read each (a copy reads only the
// first, an error none); a store beat writes the port once. The stages overlap, so
// a new beat can enter the divider while the port still serves the previous one.
// A copy or an error result skips the divider.
// Reset clears the size registers and all pipeline control; the pixel memory itself
// is not cleared and must be written before it is read.
module bilinear_image_scaler
	import bis_pkg::*;
#(
	parameter int MAX_SOURCE_DIM = 128,
	parameter int FRACTION_BITS = 16,
	parameter int MAX_DEST_DIM = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              req,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output out_item_t             result
);

`include "bilinear_image_scaler_assert.svh"

	localparam int SRC_DEPTH = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
	localparam int AW = $clog2(SRC_DEPTH);
	localparam int DW = DIM_W;
	localparam int QW = $clog2(MAX_SOURCE_DIM);
	localparam int QWE = QW + (QW % 2);
	localparam int DSTEPS = QWE / 2;
	localparam int DCW = (DSTEPS > 1) ? $clog2(DSTEPS) : 1;
	localparam int NW = DIM_W + SDIM_W;
	localparam int QR = SDIM_W + FRACTION_BITS;
	localparam int RCW = $clog2(QR);
	localparam int XAW = QR + DIM_W;
	localparam int WW = 2 * FRACTION_BITS + 1;
	localparam int PW = 8 + WW;
	localparam int SUMW = PW + 2;
	localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	// One restoring division step: returns the quotient bit above the new remainder.
	function automatic logic [DW:0] dstep(input logic [DW-1:0] rem, input logic nb,
			input logic [DW-1:0] d);
		logic [DW:0] t;
		t = {rem, nb};
		if (t >= {1'b0, d}) begin
			return {1'b1, DW'(t - {1'b0, d})};
		end
		return {1'b0, t[DW-1:0]};
	endfunction

	// Configuration registers and their clamped views.
	logic [SDIM_W-1:0] src_w_q, src_h_q;
	logic [DIM_W-1:0]  dst_w_q, dst_h_q;
	logic [SDIM_W-1:0] sw_c, sh_c, sw1_c, sh1_c;
	logic [DIM_W-1:0]  dw_c, dh_c;
	logic              cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;

	assign sw_c = (32'(src_w_q) > MAX_SOURCE_DIM) ? SDIM_W'(MAX_SOURCE_DIM) : src_w_q;
	assign sh_c = (32'(src_h_q) > MAX_SOURCE_DIM) ? SDIM_W'(MAX_SOURCE_DIM) : src_h_q;
	assign dw_c = (32'(dst_w_q) > MAX_DEST_DIM) ? DIM_W'(MAX_DEST_DIM) : dst_w_q;
	assign dh_c = (32'(dst_h_q) > MAX_DEST_DIM) ? DIM_W'(MAX_DEST_DIM) : dst_h_q;
	assign sw1_c = sw_c - SDIM_W'(1);
	assign sh1_c = sh_c - SDIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= '0;
			src_h_q <= '0;
			dst_w_q <= '0;
			dst_h_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SRC_W: src_w_q <= cfg_data[SDIM_W-1:0];
				CFG_SRC_H: src_h_q <= cfg_data[SDIM_W-1:0];
				CFG_DST_W: dst_w_q <= cfg_data;
				CFG_DST_H: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step ratio divider: xr = ((sw - 1) << F) / dw, one quotient bit per cycle.
	logic            rc_busy_q;
	logic [RCW-1:0]  rc_cnt_q;
	logic [DW-1:0]   rc_xrem_q, rc_yrem_q;
	logic [QR-1:0]   xr_q, yr_q;
	logic [QR-1:0]   rc_xnum, rc_ynum;
	logic [RCW-1:0]  rc_bit;
	logic [DW:0]     rc_xs, rc_ys;

	assign rc_xnum = {sw1_c, {FRACTION_BITS{1'b0}}};
	assign rc_ynum = {sh1_c, {FRACTION_BITS{1'b0}}};
	assign rc_bit = RCW'(QR - 1) - rc_cnt_q;
	assign rc_xs = dstep(rc_xrem_q, rc_xnum[rc_bit], dw_c);
	assign rc_ys = dstep(rc_yrem_q, rc_ynum[rc_bit], dh_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_busy_q <= 1'b0;
			rc_cnt_q <= '0;
		end else if (cfg_wr) begin
			rc_busy_q <= 1'b1;
			rc_cnt_q <= '0;
		end else if (rc_busy_q) begin
			rc_cnt_q <= rc_cnt_q + RCW'(1);
			if (rc_cnt_q == RCW'(QR - 1)) begin
				rc_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_wr) begin
			rc_xrem_q <= '0;
			rc_yrem_q <= '0;
		end else if (rc_busy_q) begin
			rc_xrem_q <= rc_xs[DW-1:0];
			rc_yrem_q <= rc_ys[DW-1:0];
			xr_q <= {xr_q[QR-2:0], rc_xs[DW]};
			yr_q <= {yr_q[QR-2:0], rc_ys[DW]};
		end
	end

	// Stage A: accepted beat, coordinate divider x0 = col*(sw-1)/dw, y0 likewise.
	logic            a_valid_q, a_done_q;
	logic [DCW-1:0]  a_cnt_q;
	in_item_t        a_req_q;
	status_t         a_status_q;
	logic            a_copy_q;
	logic [DW-1:0]   a_xrem_q, a_yrem_q;
	logic [QWE-1:0]  a_xn_q, a_yn_q, a_xq_q, a_yq_q;
	logic [DW:0]     ax1, ax2, ay1, ay2;
	logic [QWE-1:0]  a_xq_n, a_yq_n, a_x0_out, a_y0_out;
	logic            a_last_step, a_ready, a_move, b_free, acc;
	logic [NW-1:0]   acc_nx, acc_ny;
	status_t         acc_status;
	logic            acc_copy;

	assign ax1 = dstep(a_xrem_q, a_xn_q[QWE-1], dw_c);
	assign ax2 = dstep(ax1[DW-1:0], a_xn_q[QWE-2], dw_c);
	assign ay1 = dstep(a_yrem_q, a_yn_q[QWE-1], dh_c);
	assign ay2 = dstep(ay1[DW-1:0], a_yn_q[QWE-2], dh_c);
	assign a_xq_n = QWE'({a_xq_q, ax1[DW], ax2[DW]});
	assign a_yq_n = QWE'({a_yq_q, ay1[DW], ay2[DW]});
	assign a_x0_out = a_done_q ? a_xq_q : a_xq_n;
	assign a_y0_out = a_done_q ? a_yq_q : a_yq_n;

	assign a_last_step = a_valid_q && !a_done_q && (a_cnt_q == DCW'(DSTEPS - 1));
	assign a_ready = a_valid_q && (a_done_q || a_last_step);
	assign a_move = a_ready && b_free;
	assign busy = rc_busy_q | (a_valid_q & ~a_move);
	assign acc = start & ~busy;

	assign acc_nx = NW'(req.dst_col) * NW'(sw1_c);
	assign acc_ny = NW'(req.dst_row) * NW'(sh1_c);

	always_comb begin
		if (sw_c == '0 || sh_c == '0 || dw_c == '0 || dh_c == '0) begin
			acc_status = ST_ZERO;
		end else if (req.dst_col >= dw_c || req.dst_row >= dh_c) begin
			acc_status = ST_RANGE;
		end else begin
			acc_status = ST_OK;
		end
	end
	assign acc_copy = (DIM_W'(sw_c) == dw_c) && (DIM_W'(sh_c) == dh_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			a_done_q <= 1'b0;
			a_cnt_q <= '0;
		end else if (acc) begin
			a_valid_q <= 1'b1;
			a_done_q <= !req.req_type || acc_status != ST_OK || acc_copy;
			a_cnt_q <= '0;
		end else begin
			if (a_move) begin
				a_valid_q <= 1'b0;
			end
			if (a_valid_q && !a_done_q) begin
				a_cnt_q <= a_cnt_q + DCW'(1);
				if (a_last_step) begin
					a_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			a_req_q <= req;
			a_status_q <= acc_status;
			a_copy_q <= acc_copy;
			a_xrem_q <= DW'(acc_nx >> QWE);
			a_yrem_q <= DW'(acc_ny >> QWE);
			a_xn_q <= acc_nx[QWE-1:0];
			a_yn_q <= acc_ny[QWE-1:0];
			a_xq_q <= '0;
			a_yq_q <= '0;
		end else if (a_valid_q && !a_done_q) begin
			a_xrem_q <= ax2[DW-1:0];
			a_yrem_q <= ay2[DW-1:0];
			a_xn_q <= a_xn_q << 2;
			a_yn_q <= a_yn_q << 2;
			a_xq_q <= a_xq_n;
			a_yq_q <= a_yq_n;
		end
	end

	// Stage B: owns the memory port; a store writes once, a compute issues up to four reads.
	logic            b_valid_q;
	logic [1:0]      b_idx_q;
	in_item_t        b_req_q;
	status_t         b_status_q;
	logic            b_copy_q;
	logic [DIM_W-1:0] b_x0_q, b_y0_q;
	logic            b_last;
	logic [DIM_W-1:0] b_x1, b_y1, b_xs, b_ys;
	logic [NW:0]     b_addr_full;
	logic [XAW-1:0]  b_xa, b_ya, b_xb, b_yb, b_xdf, b_ydf;
	logic [FRACTION_BITS:0] b_xd, b_yd;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_addr;
	logic [31:0]     ram_wdata, ram_rdata;

	assign b_last = b_valid_q && (b_req_q.req_type == 1'b0 || b_idx_q == 2'd3);
	assign b_free = !b_valid_q || b_last;

	assign b_x1 = (b_x0_q + DIM_W'(1) < DIM_W'(sw_c)) ? b_x0_q + DIM_W'(1) : DIM_W'(sw1_c);
	assign b_y1 = (b_y0_q + DIM_W'(1) < DIM_W'(sh_c)) ? b_y0_q + DIM_W'(1) : DIM_W'(sh1_c);
	assign b_xs = b_copy_q ? b_req_q.dst_col : (b_idx_q[0] ? b_x1 : b_x0_q);
	assign b_ys = b_copy_q ? b_req_q.dst_row : (b_idx_q[1] ? b_y1 : b_y0_q);
	assign b_addr_full = (NW + 1)'(b_ys) * (NW + 1)'(sw_c) + (NW + 1)'(b_xs);

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_addr = AW'(b_addr_full);
		ram_wdata = {b_req_q.in_alpha, b_req_q.in_red, b_req_q.in_green, b_req_q.in_blue};
		if (b_valid_q && b_req_q.req_type == 1'b0) begin
			ram_addr = AW'(b_req_q.src_addr);
			ram_we = (32'(b_req_q.src_addr) < SRC_DEPTH);
		end else if (b_valid_q) begin
			ram_re = (b_status_q == ST_OK) && (!b_copy_q || b_idx_q == 2'd0);
		end
	end

	// Fractional offsets, clamped to [0, one].
	assign b_xa = XAW'(xr_q) * XAW'(b_req_q.dst_col);
	assign b_ya = XAW'(yr_q) * XAW'(b_req_q.dst_row);
	assign b_xb = XAW'(b_x0_q) << FRACTION_BITS;
	assign b_yb = XAW'(b_y0_q) << FRACTION_BITS;
	assign b_xdf = (b_xa > b_xb) ? b_xa - b_xb : '0;
	assign b_ydf = (b_ya > b_yb) ? b_ya - b_yb : '0;
	assign b_xd = (b_xdf > XAW'(ONE)) ? ONE : b_xdf[FRACTION_BITS:0];
	assign b_yd = (b_ydf > XAW'(ONE)) ? ONE : b_ydf[FRACTION_BITS:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_q <= 1'b0;
			b_idx_q <= '0;
		end else if (a_move) begin
			b_valid_q <= 1'b1;
			b_idx_q <= '0;
		end else if (b_last) begin
			b_valid_q <= 1'b0;
		end else if (b_valid_q) begin
			b_idx_q <= b_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (a_move) begin
			b_req_q <= a_req_q;
			b_status_q <= a_status_q;
			b_copy_q <= a_copy_q;
			b_x0_q <= DIM_W'(a_x0_out[QW-1:0]);
			b_y0_q <= DIM_W'(a_y0_out[QW-1:0]);
		end
	end

	bis_ram #(
		.WIDTH(32),
		.DEPTH(SRC_DEPTH)
	) u_src_ram (
		.clk(clk),
		.we(ram_we),
		.re(ram_re),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Read return stage: read data arrives in the cycle after each issue.
	logic            rd_valid_s1, rd_last_s1, rd_copy_s1;
	logic [1:0]      rd_idx_s1;
	status_t         rd_status_s1;
	logic [FRACTION_BITS:0] rd_xd_s1, rd_yd_s1;
	logic [31:0]     pix0_q, pix1_q, pix2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= b_valid_q && b_req_q.req_type == 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= b_idx_q;
		rd_last_s1 <= (b_idx_q == 2'd3);
		rd_copy_s1 <= b_copy_q;
		rd_status_s1 <= b_status_q;
		rd_xd_s1 <= b_xd;
		rd_yd_s1 <= b_yd;
		if (rd_valid_s1) begin
			case (rd_idx_s1)
				2'd0: pix0_q <= ram_rdata;
				2'd1: pix1_q <= ram_rdata;
				2'd2: pix2_q <= ram_rdata;
				default: ;
			endcase
		end
	end

	// Weight stage.
	logic            w_valid_s2, w_copy_s2;
	status_t         w_status_s2;
	logic [31:0]     pix_s2 [4];
	logic [WW-1:0]   wgt_s2 [4];
	logic [FRACTION_BITS:0] omx, omy;

	assign omx = ONE - rd_xd_s1;
	assign omy = ONE - rd_yd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_valid_s2 <= 1'b0;
		end else begin
			w_valid_s2 <= rd_valid_s1 && rd_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_copy_s2 <= rd_copy_s1;
		w_status_s2 <= rd_status_s1;
		pix_s2[0] <= pix0_q;
		pix_s2[1] <= pix1_q;
		pix_s2[2] <= pix2_q;
		pix_s2[3] <= ram_rdata;
		wgt_s2[0] <= WW'(omx) * WW'(omy);
		wgt_s2[1] <= WW'(rd_xd_s1) * WW'(omy);
		wgt_s2[2] <= WW'(rd_yd_s1) * WW'(omx);
		wgt_s2[3] <= WW'(rd_xd_s1) * WW'(rd_yd_s1);
	end

	// Product stage: one product per channel and neighbor.
	logic            p_valid_s3, p_copy_s3;
	status_t         p_status_s3;
	logic [31:0]     p_pix_s3;
	logic [PW-1:0]   prod_s3 [4][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_valid_s3 <= 1'b0;
		end else begin
			p_valid_s3 <= w_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_copy_s3 <= w_copy_s2;
		p_status_s3 <= w_status_s2;
		p_pix_s3 <= pix_s2[0];
		for (int c = 0; c < 4; c++) begin
			for (int n = 0; n < 4; n++) begin
				prod_s3[c][n] <= PW'(pix_s2[n][8*c +: 8]) * PW'(wgt_s2[n]);
			end
		end
	end

	// Output stage: sum, scale down, saturate, or pass the copy or error value.
	logic [7:0]      chan [4];
	logic            result_valid_q;
	out_item_t       result_q;

	always_comb begin
		logic [SUMW-1:0] s;
		logic [SUMW-1:0] sh;
		for (int c = 0; c < 4; c++) begin
			s = SUMW'(prod_s3[c][0]) + SUMW'(prod_s3[c][1])
				+ SUMW'(prod_s3[c][2]) + SUMW'(prod_s3[c][3]);
			sh = s >> (2 * FRACTION_BITS);
			if (p_status_s3 != ST_OK) begin
				chan[c] = 8'd0;
			end else if (p_copy_s3) begin
				chan[c] = p_pix_s3[8*c +: 8];
			end else if (sh > SUMW'(255)) begin
				chan[c] = 8'd255;
			end else begin
				chan[c] = sh[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= p_valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_blue <= chan[0];
		result_q.out_green <= chan[1];
		result_q.out_red <= chan[2];
		result_q.out_alpha <= chan[3];
		result_q.status <= p_status_s3;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`BIS_ASSERT_NEVER(a_ram_rw, clk, arst_n, ram_we && ram_re, "memory port written and read together")
	`BIS_ASSERT(a_launch_lat, clk, arst_n, rd_valid_s1 && rd_last_s1 |-> ##3 result_valid_q, "result strobe missing after last neighbor read")
	`BIS_ASSERT(a_err_zero, clk, arst_n, result_valid_q && result_q.status != ST_OK |-> result_q.out_blue == 8'd0 && result_q.out_green == 8'd0 && result_q.out_red == 8'd0 && result_q.out_alpha == 8'd0, "error result carries nonzero channels")
	`BIS_ASSERT(a_x0_range, clk, arst_n, a_move && a_req_q.req_type && a_status_q == ST_OK && !a_copy_q |-> DIM_W'(a_x0_out[QW-1:0]) < DIM_W'(sw_c), "column quotient outside source width")
	`BIS_ASSERT_NEVER(a_div_cfg, clk, arst_n, rc_busy_q && rd_valid_s1 && rd_last_s1 && !rd_copy_s1 && rd_status_s1 == ST_OK, "interpolation used ratios still being computed")

endmodule

FILE: hw/rtl/bis_ram.sv
module bis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: dv/tb_bilinear_image_scaler.sv
`timescale 1ns / 1ps

module tb_bilinear_image_scaler;
	import bis_pkg::*;

	localparam int MEM_DEPTH = 16384;
	localparam int SRC_MAX = 128;
	localparam int DST_MAX = 4096;
	localparam int FRAC = 16;
	// Idle wait after the last result has come back, so that any store still in flight
	// has reached the memory.
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t req = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic result_valid;
	out_item_t result;

	bilinear_image_scaler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Our own copy of the size registers and of the source pixel memory. Both are
	// updated when the corresponding beat is accepted by the block.
	logic [7:0] src_w_reg = '0;
	logic [7:0] src_h_reg = '0;
	logic [11:0] dst_w_reg = '0;
	logic [11:0] dst_h_reg = '0;
	logic [31:0] pixel_mem [MEM_DEPTH];

	// Entries that the stimulus has already scheduled a store for. A compute beat is
	// only queued after every source pixel it will read has a store ahead of it.
	bit pixel_planned [MEM_DEPTH];

	in_item_t pending_beats [$];
	out_item_t pixels_expected [$];

	int idle_pct = 0;
	bit hold_off = 1'b0;
	bit beat_taken = 1'b0;
	bit cfg_taken = 1'b0;

	int mismatches = 0;
	int stores_done = 0;
	int computes_done = 0;
	int results_seen = 0;
	int status_hits [3] = '{0, 0, 0};
	int stall_cycles = 0;

	// Works out where a destination pixel falls in the source image under the current
	// sizes. Returns the status, whether it is a plain copy, the four neighbor
	// coordinates and the fixed-point fractions.
	function automatic status_t locate(input logic [11:0] col, input logic [11:0] row,
			output bit copy, output int unsigned x0, output int unsigned y0,
			output int unsigned x1, output int unsigned y1,
			output longint unsigned xd, output longint unsigned yd);
		longint unsigned one;
		longint unsigned sw, sh, dw, dh, xr, yr, xa, xb, ya, yb;
		one = longint'(1) << FRAC;
		sw = (src_w_reg > SRC_MAX) ? SRC_MAX : src_w_reg;
		sh = (src_h_reg > SRC_MAX) ? SRC_MAX : src_h_reg;
		dw = (dst_w_reg > DST_MAX) ? DST_MAX : dst_w_reg;
		dh = (dst_h_reg > DST_MAX) ? DST_MAX : dst_h_reg;
		copy = 1'b0;
		x0 = 0; y0 = 0; x1 = 0; y1 = 0; xd = 0; yd = 0;
		if (sw == 0 || sh == 0 || dw == 0 || dh == 0)
			return ST_ZERO;
		if (col >= dw || row >= dh)
			return ST_RANGE;
		if (sw == dw && sh == dh) begin
			copy = 1'b1;
			x0 = col; y0 = row; x1 = col; y1 = row;
			return ST_OK;
		end
		xr = ((sw - 1) * one) / dw;
		yr = ((sh - 1) * one) / dh;
		x0 = (longint'(col) * (sw - 1)) / dw;
		y0 = (longint'(row) * (sh - 1)) / dh;
		xa = xr * col;
		xb = longint'(x0) * one;
		ya = yr * row;
		yb = longint'(y0) * one;
		// A step ratio that truncated low can leave the fraction negative; it clamps to 0.
		xd = (xa > xb) ? xa - xb : 0;
		yd = (ya > yb) ? ya - yb : 0;
		if (xd > one) xd = one;
		if (yd > one) yd = one;
		// Right and lower neighbors never leave the source image.
		x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
		y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
		return ST_OK;
	endfunction

	function automatic int unsigned raster_addr(input int unsigned x, input int unsigned y);
		int unsigned sw;
		sw = (src_w_reg > SRC_MAX) ? SRC_MAX : src_w_reg;
		return y * sw + x;
	endfunction

	// Interpolated BGRA pixel for one destination coordinate.
	function automatic out_item_t interpolate_pixel(input logic [11:0] col,
			input logic [11:0] row);
		out_item_t px;
		bit copy;
		int unsigned x0, y0, x1, y1;
		longint unsigned xd, yd, one, sum;
		longint unsigned wgt [4];
		logic [31:0] nb [4];
		logic [7:0] chan [4];
		px = '0;
		px.status = locate(col, row, copy, x0, y0, x1, y1, xd, yd);
		if (px.status != ST_OK)
			return px;
		nb[0] = pixel_mem[raster_addr(x0, y0)];
		nb[1] = pixel_mem[raster_addr(x1, y0)];
		nb[2] = pixel_mem[raster_addr(x0, y1)];
		nb[3] = pixel_mem[raster_addr(x1, y1)];
		if (copy) begin
			for (int k = 0; k < 4; k++)
				chan[k] = nb[0][8*k +: 8];
		end else begin
			one = longint'(1) << FRAC;
			wgt[0] = (one - xd) * (one - yd);
			wgt[1] = xd * (one - yd);
			wgt[2] = yd * (one - xd);
			wgt[3] = xd * yd;
			for (int k = 0; k < 4; k++) begin
				sum = 0;
				for (int n = 0; n < 4; n++)
					sum += longint'(nb[n][8*k +: 8]) * wgt[n];
				sum = sum >> (2 * FRAC);
				chan[k] = (sum > 255) ? 8'd255 : sum[7:0];
			end
		end
		px.out_blue = chan[0];
		px.out_green = chan[1];
		px.out_red = chan[2];
		px.out_alpha = chan[3];
		return px;
	endfunction

	function automatic in_item_t random_beat();
		in_item_t it;
		it.req_type = $urandom_range(0, 1);
		it.src_addr = $urandom;
		it.in_blue = $urandom;
		it.in_green = $urandom;
		it.in_red = $urandom;
		it.in_alpha = $urandom;
		it.dst_col = $urandom;
		it.dst_row = $urandom;
		return it;
	endfunction

	task automatic queue_store(input logic [13:0] addr);
		in_item_t it;
		it = random_beat();
		it.req_type = 1'b0;
		it.src_addr = addr;
		pixel_planned[addr] = 1'b1;
		pending_beats.push_back(it);
	endtask

	// Queues a compute beat, preceded by stores for every neighbor with no store scheduled yet.
	task automatic queue_compute(input logic [11:0] col, input logic [11:0] row);
		in_item_t it;
		bit copy;
		int unsigned x0, y0, x1, y1, a;
		longint unsigned xd, yd;
		if (locate(col, row, copy, x0, y0, x1, y1, xd, yd) == ST_OK) begin
			for (int n = 0; n < 4; n++) begin
				a = raster_addr(n[0] ? x1 : x0, n[1] ? y1 : y0);
				if (!pixel_planned[a])
					queue_store(a);
			end
		end
		it = random_beat();
		it.req_type = 1'b1;
		it.dst_col = col;
		it.dst_row = row;
		pending_beats.push_back(it);
	endtask

	// Stops new beats and waits until the block has nothing left to do.
	task automatic drain();
		hold_off = 1'b1;
		do
			@(negedge clk);
		while (start || pixels_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all four size registers while the block is idle. Valid stays high from
	// one beat to the next and is lowered only after the last one.
	task automatic program_sizes(input logic [11:0] sw, input logic [11:0] sh,
			input logic [11:0] dw, input logic [11:0] dh);
		logic [11:0] vals [4];
		cfg_idx_t idx;
		vals = '{sw, sh, dw, dh};
		drain();
		idx = CFG_SRC_W;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[i];
			do
				@(negedge clk);
			while (!cfg_taken);
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
		// Pending beats are held until the register beats are in.
		hold_off = 1'b0;
	endtask

	// Feeds one batch of beats and waits for all of them to be taken.
	task automatic run_batch();
		while (pending_beats.size() != 0 || start)
			@(negedge clk);
	endtask

	task automatic random_phase(input int beats, input int idle);
		logic [11:0] sw, sh, dw, dh, col, row;
		int made;
		idle_pct = idle;
		sw = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 12);
		sh = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 255) : $urandom_range(1, 12);
		case ($urandom_range(0, 5))
			0: begin dw = sw; dh = sh; end
			1: begin dw = 4095; dh = $urandom_range(1, 40); end
			2: begin dw = $urandom_range(0, 1); dh = $urandom_range(0, 3); end
			default: begin dw = $urandom_range(1, 40); dh = $urandom_range(1, 40); end
		endcase
		program_sizes(sw, sh, dw, dh);
		made = 0;
		while (made < beats) begin
			if ($urandom_range(0, 99) < 20) begin
				queue_store($urandom);
			end else begin
				if ($urandom_range(0, 99) < 85 && dst_w_reg != 0 && dst_h_reg != 0) begin
					col = $urandom_range(0, dst_w_reg - 1);
					row = $urandom_range(0, dst_h_reg - 1);
				end else begin
					col = $urandom;
					row = $urandom;
				end
				queue_compute(col, row);
			end
			made++;
			// Feed in small batches so the sender can be held part way through.
			if (made % 10 == 0) begin
				run_batch();
				if (made / 10 == beats / 20 && idle == 6) begin
					drain();
					hold_off = 1'b0;
				end
			end
		end
		run_batch();
	endtask

	// Sender: presents the next queued beat at the falling edge, with random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			if (hold_off || pending_beats.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
				start <= 1'b0;
			end else begin
				req <= pending_beats.pop_front();
				start <= 1'b1;
			end
		end
	end

	// Monitor: checks results, then records accepted beats and register writes.
	always @(posedge clk) begin
		out_item_t want;
		beat_taken <= arst_n && start && !busy;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (result_valid) begin
				results_seen++;
				if (result.status <= ST_RANGE)
					status_hits[result.status]++;
				if (pixels_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %h", result);
				end else begin
					want = pixels_expected.pop_front();
					if (result.out_blue !== want.out_blue || result.out_green !== want.out_green
							|| result.out_red !== want.out_red
							|| result.out_alpha !== want.out_alpha
							|| result.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel mismatch: want b%h g%h r%h a%h st%0d, got b%h g%h r%h a%h st%0d",
								want.out_blue, want.out_green, want.out_red, want.out_alpha,
								want.status, result.out_blue, result.out_green,
								result.out_red, result.out_alpha, result.status);
					end
				end
			end
			if (start && !busy) begin
				if (req.req_type == 1'b0) begin
					pixel_mem[req.src_addr] <= {req.in_alpha, req.in_red, req.in_green,
						req.in_blue};
					stores_done++;
				end else begin
					pixels_expected.push_back(interpolate_pixel(req.dst_col, req.dst_row));
					computes_done++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SRC_W: src_w_reg <= cfg_data[7:0];
					CFG_SRC_H: src_h_reg <= cfg_data[7:0];
					CFG_DST_W: dst_w_reg <= cfg_data;
					CFG_DST_H: dst_h_reg <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Watchdog: any cycle that moves no beat anywhere counts toward the limit.
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// With every size still zero, any compute reports a zero size.
		queue_compute(12'd0, 12'd0);
		queue_compute(12'hFFF, 12'hFFF);
		run_batch();

		// Upscale a 4x3 image to 7x5: corners, edges and both kinds of range error.
		program_sizes(12'd4, 12'd3, 12'd7, 12'd5);
		queue_store(14'd0);
		queue_store(14'h3FFF);
		pending_beats[0].in_blue = 8'h00; pending_beats[0].in_alpha = 8'hFF;
		pending_beats[1].in_blue = 8'hFF; pending_beats[1].in_alpha = 8'h00;
		queue_compute(12'd0, 12'd0);
		queue_compute(12'd6, 12'd4);
		queue_compute(12'd3, 12'd2);
		queue_compute(12'd7, 12'd0);
		queue_compute(12'd0, 12'd5);
		queue_compute(12'hFFF, 12'hFFF);
		run_batch();

		// Equal sizes copy the source pixel straight through.
		program_sizes(12'd4, 12'd3, 12'd4, 12'd3);
		queue_compute(12'd0, 12'd0);
		queue_compute(12'd3, 12'd2);
		run_batch();

		// Oversized source sizes saturate to the largest image; large downscale.
		program_sizes(12'hFFF, 12'd200, 12'd4095, 12'd3);
		queue_compute(12'd4094, 12'd2);
		queue_compute(12'd1, 12'd1);
		run_batch();
		program_sizes(12'd128, 12'd128, 12'd3, 12'd2);
		queue_compute(12'd2, 12'd1);
		queue_compute(12'd1, 12'd0);
		run_batch();

		// A zero destination height gives a zero-size status again.
		program_sizes(12'd5, 12'd5, 12'd9, 12'd0);
		queue_compute(12'd1, 12'd0);
		run_batch();

		for (int p = 0; p < 9; p++)
			random_phase(64, (p < 3) ? 6 : (p < 6) ? 78 : 0);

		drain();
		$display("covered %0d stores and %0d computes, %0d results checked",
			stores_done, computes_done, results_seen);
		$display("status ok %0d, zero size %0d, out of range %0d",
			status_hits[ST_OK], status_hits[ST_ZERO], status_hits[ST_RANGE]);
		if (mismatches == 0 && pixels_expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
